/* rtl/core/cnm_pkg.sv */
// Shared constants, codes and control structs of the cosine nearest-match table.
package cnm_pkg;

   localparam int ENTRIES = 64;
   localparam int DIM     = 128;

   localparam int OP_W     = 2;
   localparam int SLOT_FW  = 6;
   localparam int ELEM_W   = 16;
   localparam int STATUS_W = 3;
   localparam int SCORE_W  = 16;

   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CNT_W  = $clog2(DIM + 2);
   localparam int ADDR_W = (ENTRIES * DIM > 1) ? $clog2(ENTRIES * DIM) : 1;

   // A square of one element fits 2*ELEM_W-1 unsigned bits; DIM of them add up.
   localparam int SQ_W   = 2 * ELEM_W - 1;
   localparam int NORM_W = SQ_W + $clog2(DIM + 1);
   localparam int ROOT_W = (NORM_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int DOT_W  = NORM_W + 1;
   localparam int DEN_W  = 2 * ROOT_W;
   localparam int Q_W    = 16;

   localparam int HALF_SCORE = 32768;
   localparam int MAX_SCORE  = 65535;

   localparam logic [SCORE_W-1:0] THRESH_RESET = SCORE_W'(49152);

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_DEL = 2'd1;
   localparam logic [OP_W-1:0] OP_QRY = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STS_IN_USE   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_MATCH    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NO_MATCH = 3'd4;
   localparam logic [STATUS_W-1:0] STS_LEN_ERR  = 3'd5;

   typedef struct packed {
      logic take;
      logic commit_add;
      logic qroot_load;
      logic scan_init;
      logic dot_start;
      logic div_start;
      logic score_upd;
      logic scan_next;
      logic rsp_commit;
      logic rsp_query;
   } cmd_type;

   typedef struct packed {
      logic ev_result;
      logic ev_commit;
      logic ev_query;
      logic sqrt_done;
      logic dot_done;
      logic div_done;
      logic slot_live;
      logic scan_last;
   } stat_type;

endpackage

/* rtl/core/cnm_if.sv */
// Channel interfaces of the cosine nearest-match table: request, response and register write.
interface cnm_req_if;
   import cnm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic [SLOT_FW-1:0]       slot;
   logic signed [ELEM_W-1:0] element;
   logic                     last;
   modport source (output valid, opcode, slot, element, last, input ready);
   modport sink   (input valid, opcode, slot, element, last, output ready);
endinterface

interface cnm_rsp_if;
   import cnm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [SLOT_FW-1:0]   match_slot;
   logic [SCORE_W-1:0]   best_score;
   modport source (output valid, status, match_slot, best_score, input ready);
   modport sink   (input valid, status, match_slot, best_score, output ready);
endinterface

interface cnm_csr_if;
   import cnm_pkg::*;
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/cosine_nearest_match_table_unit.sv */
// Top level of the cosine nearest-match table: channels, controller and datapath.
//
// The table holds ENTRIES vectors of DIM signed Q2.14 elements and streams one element per
// request beat. Add and query elements that give no result leave the controller idle. The
// last beat of a valid add is followed by an integer square root of the vector's norm, one bit
// per cycle, and its response is registered once the root is done. The last beat of a valid
// query computes the query root the same way and then scans the slots in order: an empty
// slot passes through the select and next states, and a live slot runs a dot product, with the
// single read port of the vector memory feeding one multiply-accumulate per cycle, followed by
// a restoring divide. Deletes and length or slot errors have their response registered in the
// cycle after the beat. The response sits in an output register; a new beat is taken while it
// waits only if it is being read out in the same cycle. The threshold register may be written
// at any time and is read only when a query result is formed.
module cosine_nearest_match_table_unit (
   input  logic      clock,
   input  logic      reset,
   cnm_req_if.sink   req_bus,
   cnm_rsp_if.source rsp_bus,
   cnm_csr_if.sink   csr_bus
);
   import cnm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The threshold register never stalls a write.
   assign csr_bus.ready = 1'b1;

   cnm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cnm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_bus.opcode),
      .req_slot       (req_bus.slot),
      .req_element    (req_bus.element),
      .req_last       (req_bus.last),
      .csr_write      (csr_bus.valid),
      .csr_data       (csr_bus.data),
      .rsp_status     (rsp_bus.status),
      .rsp_match_slot (rsp_bus.match_slot),
      .rsp_best_score (rsp_bus.best_score)
   );

endmodule

/* rtl/core/cnm_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
module cnm_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cnm_pkg::NORM_W-1:0] radicand,
   output logic                       done,
   output logic [cnm_pkg::ROOT_W-1:0] root
);
   import cnm_pkg::*;

   localparam int ITER_CW = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ITER_CW-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ROOT_W+3:0]   rem_t;
   logic [ROOT_W+3:0]   trial;
   logic                ge;

   always_comb begin
      rem_t   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_t >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = RAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ge ? (ROOT_W+2)'(rem_t - trial) : (ROOT_W+2)'(rem_t);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ITER_CW'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/core/cnm_div.sv */
// Restoring divider that gives floor(mag * 32768 / den), capped at 32768.
module cnm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cnm_pkg::NORM_W-1:0] mag,
   input  logic [cnm_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [cnm_pkg::Q_W-1:0]    quo
);
   import cnm_pkg::*;

   localparam int CMP_W  = ((NORM_W > DEN_W) ? NORM_W : DEN_W) + 2;
   localparam int ITER_CW = $clog2(Q_W + 1);

   logic [DEN_W:0]      rem_ff, rem_in;
   logic [Q_W-1:0]      q_ff, q_in;
   logic [ITER_CW-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                ge;
   logic [DEN_W:0]      rem_sub;
   logic                over;

   always_comb begin
      // A quotient of 65536 or more only ever gets capped, so skip the work.
      over    = CMP_W'(mag) >= (CMP_W'(den) << 1);
      ge      = rem_ff >= (DEN_W+1)'(den);
      rem_sub = ge ? rem_ff - (DEN_W+1)'(den) : rem_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = (DEN_W+1)'(mag);
         q_in    = '0;
         cnt_in  = '0;
         if (over) begin
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = {rem_sub[DEN_W-1:0], 1'b0};
         q_in   = {q_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_CW'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = (q_ff > Q_W'(HALF_SCORE)) ? Q_W'(HALF_SCORE) : q_ff;

endmodule

/* rtl/core/cnm_datapath.sv */
// Datapath: stream bookkeeping, vector memories, dot product, root, divide and best-score tracking.
module cnm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cnm_pkg::cmd_type                    cmd,
   output cnm_pkg::stat_type                   stat,
   input  logic [cnm_pkg::OP_W-1:0]            req_opcode,
   input  logic [cnm_pkg::SLOT_FW-1:0]         req_slot,
   input  logic signed [cnm_pkg::ELEM_W-1:0]   req_element,
   input  logic                                req_last,
   input  logic                                csr_write,
   input  logic [cnm_pkg::SCORE_W-1:0]         csr_data,
   output logic [cnm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cnm_pkg::SLOT_FW-1:0]         rsp_match_slot,
   output logic [cnm_pkg::SCORE_W-1:0]         rsp_best_score
);
   import cnm_pkg::*;

   // Storage.
   logic [ELEM_W-1:0] store_mem [ENTRIES*DIM];
   logic [ELEM_W-1:0] qbuf_mem  [DIM];
   logic [ROOT_W-1:0] root_mem  [ENTRIES];
   logic              valid_ff  [ENTRIES];

   // Stream state.
   logic              open_ff;
   logic [OP_W-1:0]   sop_ff;
   logic [SLOT_FW-1:0] sslot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NORM_W-1:0] norm_ff;
   logic [SLOT_W-1:0] commit_slot_ff;
   logic [SCORE_W-1:0] thr_ff;

   // Item classification.
   logic              op_add, op_del, op_qry;
   logic [SLOT_W-1:0] slot_idx;
   logic              slot_in_range, slot_used, switch_s, room, len_ok, add_bad;
   logic [CNT_W-1:0]  cnt_eff, cnt_new;
   logic [NORM_W-1:0] norm_eff, norm_new;
   logic signed [2*ELEM_W-1:0] sq;
   logic [STATUS_W-1:0] imm_status;
   logic [ADDR_W-1:0] wr_addr;

   // Scan and dot product.
   logic [SLOT_W-1:0] scan_ff;
   logic [DIM_W-1:0]  ei_ff;
   logic              issue_ff, v1_ff, l1_ff, v2_ff, l2_ff, dot_done_ff;
   logic [ELEM_W-1:0] st_q_ff, qb_q_ff;
   logic signed [2*ELEM_W-1:0] prod_ff;
   logic signed [DOT_W-1:0] acc_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ROOT_W-1:0] root_rd_ff, qroot_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              neg_ff, den_zero_ff;
   logic [NORM_W-1:0] mag;
   logic [SCORE_W-1:0] best_ff;
   logic [SLOT_W-1:0] mslot_ff;
   logic [SCORE_W:0]  score_pos;
   logic [SCORE_W-1:0] score;

   // Arithmetic units; the square root serves both adds and queries.
   logic              sqrt_start, sqrt_done, div_done;
   logic [ROOT_W-1:0] sqrt_root;
   logic [Q_W-1:0]    div_q;

   always_comb begin
      op_add   = req_opcode == OP_ADD;
      op_del   = req_opcode == OP_DEL;
      op_qry   = req_opcode == OP_QRY;
      slot_idx = SLOT_W'(req_slot);
      slot_in_range = 32'(req_slot) < ENTRIES;
      slot_used = slot_in_range && valid_ff[slot_idx];
      switch_s = open_ff && (sop_ff != req_opcode || (op_add && sslot_ff != req_slot));
      cnt_eff  = switch_s ? '0 : cnt_ff;
      norm_eff = switch_s ? '0 : norm_ff;
      room     = 32'(cnt_eff) < DIM;
      sq       = req_element * req_element;
      cnt_new  = room ? cnt_eff + 1'b1 : CNT_W'(DIM + 1);
      norm_new = room ? norm_eff + NORM_W'(sq[SQ_W-1:0]) : norm_eff;
      len_ok   = cnt_new == CNT_W'(DIM);
      add_bad  = !slot_in_range || slot_used;
      wr_addr  = ADDR_W'(slot_idx) * ADDR_W'(DIM) + ADDR_W'(cnt_eff);

      stat.ev_result = op_del || (req_last && op_add && (add_bad || !len_ok))
                       || (req_last && op_qry && !len_ok);
      stat.ev_commit = req_last && op_add && !add_bad && len_ok;
      stat.ev_query  = req_last && op_qry && len_ok;
      stat.sqrt_done = sqrt_done;
      stat.dot_done  = dot_done_ff;
      stat.div_done  = div_done;
      stat.slot_live = valid_ff[scan_ff];
      stat.scan_last = scan_ff == SLOT_W'(ENTRIES - 1);

      if (op_del) begin
         imm_status = slot_used ? STS_OK : STS_EMPTY;
      end else if (op_add && add_bad) begin
         imm_status = STS_IN_USE;
      end else begin
         imm_status = STS_LEN_ERR;
      end

      sqrt_start = cmd.take && (stat.ev_commit || stat.ev_query);
      rd_addr    = ADDR_W'(scan_ff) * ADDR_W'(DIM) + ADDR_W'(ei_ff);
      mag        = acc_ff[DOT_W-1] ? NORM_W'(-acc_ff) : NORM_W'(acc_ff);

      score_pos = (SCORE_W+1)'(HALF_SCORE) + (SCORE_W+1)'(div_q);
      if (neg_ff) begin
         score = SCORE_W'((SCORE_W+1)'(HALF_SCORE) - (SCORE_W+1)'(div_q));
      end else if (score_pos > (SCORE_W+1)'(MAX_SCORE)) begin
         score = SCORE_W'(MAX_SCORE);
      end else begin
         score = score_pos[SCORE_W-1:0];
      end
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.take && op_add && room && !add_bad) begin
         store_mem[wr_addr] <= req_element;
      end
      if (cmd.take && op_qry && room) begin
         qbuf_mem[DIM_W'(cnt_eff)] <= req_element;
      end
      if (cmd.commit_add) begin
         root_mem[commit_slot_ff] <= sqrt_root;
      end
      st_q_ff    <= store_mem[rd_addr];
      qb_q_ff    <= qbuf_mem[ei_ff];
      root_rd_ff <= root_mem[scan_ff];
   end

   // Valid bits and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         open_ff <= 1'b0;
         cnt_ff  <= '0;
         norm_ff <= '0;
         thr_ff  <= THRESH_RESET;
      end else begin
         if (csr_write) begin
            thr_ff <= csr_data;
         end
         if (cmd.take && op_del && slot_used) begin
            valid_ff[slot_idx] <= 1'b0;
         end
         if (cmd.commit_add) begin
            valid_ff[commit_slot_ff] <= 1'b1;
         end
         if (cmd.take && (op_add || op_qry)) begin
            if (req_last) begin
               open_ff <= 1'b0;
               cnt_ff  <= '0;
               norm_ff <= '0;
            end else begin
               open_ff <= 1'b1;
               cnt_ff  <= cnt_new;
               norm_ff <= norm_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      // Deletes and ignored opcodes leave the open stream's identity alone.
      if (cmd.take && (op_add || op_qry)) begin
         sop_ff   <= req_opcode;
         sslot_ff <= req_slot;
      end
      if (sqrt_start) begin
         commit_slot_ff <= slot_idx;
      end
      if (cmd.qroot_load) begin
         qroot_ff <= sqrt_root;
      end
      den_ff <= DEN_W'(root_rd_ff * qroot_ff);
      if (cmd.div_start) begin
         neg_ff      <= acc_ff[DOT_W-1];
         den_zero_ff <= den_ff == '0;
      end
      if (cmd.scan_init) begin
         scan_ff  <= '0;
         best_ff  <= '0;
         mslot_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.score_upd && !den_zero_ff && score > best_ff) begin
         best_ff  <= score;
         mslot_ff <= scan_ff;
      end
   end

   // Dot product pipeline: address, read data, product, accumulate.
   always_ff @(posedge clock) begin
      prod_ff <= $signed(st_q_ff) * $signed(qb_q_ff);
      if (cmd.dot_start) begin
         ei_ff  <= '0;
         acc_ff <= '0;
      end else begin
         if (issue_ff) begin
            ei_ff <= ei_ff + 1'b1;
         end
         if (v2_ff) begin
            acc_ff <= acc_ff + DOT_W'(prod_ff);
         end
      end
      if (reset) begin
         issue_ff    <= 1'b0;
         v1_ff       <= 1'b0;
         l1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         l2_ff       <= 1'b0;
         dot_done_ff <= 1'b0;
      end else begin
         if (cmd.dot_start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && ei_ff == DIM_W'(DIM - 1)) begin
            issue_ff <= 1'b0;
         end
         v1_ff       <= issue_ff && !cmd.dot_start;
         l1_ff       <= issue_ff && !cmd.dot_start && ei_ff == DIM_W'(DIM - 1);
         v2_ff       <= v1_ff;
         l2_ff       <= l1_ff;
         dot_done_ff <= v2_ff && l2_ff;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (cmd.take && stat.ev_result) begin
         rsp_status     <= imm_status;
         rsp_match_slot <= '0;
         rsp_best_score <= '0;
      end else if (cmd.rsp_commit) begin
         rsp_status     <= STS_OK;
         rsp_match_slot <= '0;
         rsp_best_score <= '0;
      end else if (cmd.rsp_query) begin
         rsp_best_score <= best_ff;
         if (best_ff > thr_ff) begin
            rsp_status     <= STS_MATCH;
            rsp_match_slot <= SLOT_FW'(mslot_ff);
         end else begin
            rsp_status     <= STS_NO_MATCH;
            rsp_match_slot <= '0;
         end
      end
   end

   cnm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (norm_new),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   cnm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .mag   (mag),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_q)
   );

endmodule

/* rtl/core/cnm_ctrl.sv */
// Controller state machine that sequences item intake, entry commit and the query scan.
module cnm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cnm_pkg::stat_type   stat,
   output cnm_pkg::cmd_type    cmd
);
   import cnm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT_ADD,
      ST_ROOT_QRY,
      ST_SEL,
      ST_DOT,
      ST_DIV,
      ST_NEXT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      cmd          = '0;
      cmd.take     = req_valid && req_ready;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take) begin
               if (stat.ev_result) begin
                  rsp_valid_in = 1'b1;
               end
               if (stat.ev_commit) begin
                  state_in = ST_ROOT_ADD;
               end else if (stat.ev_query) begin
                  state_in = ST_ROOT_QRY;
               end
            end
         end
         ST_ROOT_ADD: begin
            if (stat.sqrt_done) begin
               cmd.commit_add = 1'b1;
               cmd.rsp_commit = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ROOT_QRY: begin
            if (stat.sqrt_done) begin
               cmd.qroot_load = 1'b1;
               cmd.scan_init  = 1'b1;
               state_in       = ST_SEL;
            end
         end
         ST_SEL: begin
            if (stat.slot_live) begin
               cmd.dot_start = 1'b1;
               state_in      = ST_DOT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DOT: begin
            if (stat.dot_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.score_upd = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (stat.scan_last) begin
               cmd.rsp_query = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SEL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_sqrt_done_in_root: assert property (@(posedge clock) disable iff (reset)
      stat.sqrt_done |-> (state_ff == ST_ROOT_ADD || state_ff == ST_ROOT_QRY))
      else $error("square root finished outside a root state");

   a_dot_done_in_dot: assert property (@(posedge clock) disable iff (reset)
      stat.dot_done |-> state_ff == ST_DOT)
      else $error("dot product finished outside the dot state");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_commit || cmd.rsp_query) |-> !rsp_valid_ff)
      else $error("scan or commit result would overwrite a pending result");

   a_query_starts_root: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && stat.ev_query) |=> state_ff == ST_ROOT_QRY && !rsp_valid_ff)
      else $error("query intake did not start the root computation");
`endif

endmodule

/* tb/cnm_match_checker.sv */
// Predicts the results of the cosine nearest-match table and compares them with its responses.
module cnm_match_checker (
   input  logic clock,
   input  logic reset,
   cnm_req_if   req_bus,
   cnm_rsp_if   rsp_bus,
   cnm_csr_if   csr_bus,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   import cnm_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_FW-1:0]  match_slot;
      logic [SCORE_W-1:0]  best_score;
   } result_type;

   result_type awaited_results[$];

   logic signed [ELEM_W-1:0] table_vec[ENTRIES][DIM];
   logic signed [ELEM_W-1:0] probe_vec[DIM];
   bit                       slot_live[ENTRIES];
   longint unsigned          slot_norm[ENTRIES];
   longint unsigned          acc_norm;
   int                       elem_cnt;
   bit                       in_stream;
   logic [OP_W-1:0]          stream_code;
   logic [SLOT_FW-1:0]       stream_slot;
   logic [SCORE_W-1:0]       threshold;

   // Floor square root, one result bit at a time from the top.
   function automatic longint unsigned int_root(input longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned slot_score(input int s, input longint unsigned qroot);
      longint          dot;
      longint unsigned den, mag, q, sc;
      dot = 0;
      for (int i = 0; i < DIM; i++) dot += longint'(table_vec[s][i]) * longint'(probe_vec[i]);
      den = int_root(slot_norm[s]) * qroot;
      if (den == 0) return 0;
      mag = (dot < 0) ? longint'(-dot) : dot;
      q   = (mag * HALF_SCORE) / den;
      if (q > HALF_SCORE) q = HALF_SCORE;
      sc = (dot < 0) ? HALF_SCORE - q : HALF_SCORE + q;
      if (sc > MAX_SCORE) sc = MAX_SCORE;
      return sc;
   endfunction

   task automatic take_beat(input logic [OP_W-1:0] op, input logic [SLOT_FW-1:0] s,
                            input logic signed [ELEM_W-1:0] e, input logic l);
      result_type      r;
      longint unsigned qroot, sc, best;
      r = '{status: STS_OK, match_slot: '0, best_score: '0};
      if (op != OP_ADD && op != OP_DEL && op != OP_QRY) return;
      if (op == OP_DEL) begin
         if (slot_live[s]) slot_live[s] = 1'b0;
         else r.status = STS_EMPTY;
         awaited_results.insert(awaited_results.size(), r);
         return;
      end
      if (in_stream && (stream_code != op || (op == OP_ADD && stream_slot != s))) begin
         elem_cnt = 0;
         acc_norm = 0;
      end
      in_stream   = 1'b1;
      stream_code = op;
      stream_slot = s;
      if (elem_cnt < DIM) begin
         if (op == OP_ADD) begin
            if (!slot_live[s]) table_vec[s][elem_cnt] = e;
         end else begin
            probe_vec[elem_cnt] = e;
         end
         acc_norm += longint'(e) * longint'(e);
         elem_cnt++;
      end else begin
         elem_cnt = DIM + 1;
      end
      if (!l) return;
      if (op == OP_ADD) begin
         if (slot_live[s]) r.status = STS_IN_USE;
         else if (elem_cnt != DIM) r.status = STS_LEN_ERR;
         else begin
            slot_live[s] = 1'b1;
            slot_norm[s] = acc_norm;
         end
      end else if (elem_cnt != DIM) begin
         r.status = STS_LEN_ERR;
      end else begin
         qroot = int_root(acc_norm);
         best  = 0;
         for (int k = 0; k < ENTRIES; k++) begin
            if (slot_live[k]) begin
               sc = slot_score(k, qroot);
               if (sc > best) begin
                  best         = sc;
                  r.match_slot = SLOT_FW'(k);
               end
            end
         end
         r.best_score = SCORE_W'(best);
         if (best > threshold) r.status = STS_MATCH;
         else begin
            r.status     = STS_NO_MATCH;
            r.match_slot = '0;
         end
      end
      in_stream = 1'b0;
      elem_cnt  = 0;
      acc_norm  = 0;
      awaited_results.insert(awaited_results.size(), r);
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      for (int k = 0; k < ENTRIES; k++) slot_live[k] = 1'b0;
      acc_norm  = 0;
      elem_cnt  = 0;
      in_stream = 1'b0;
      threshold = THRESH_RESET;
   end

   always @(posedge clock) begin
      result_type x;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked++;
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response status %0d slot %0d score %0d", $time,
                        rsp_bus.status, rsp_bus.match_slot, rsp_bus.best_score);
            end else begin
               x = awaited_results.pop_front();
               if (rsp_bus.status !== x.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d", $time, x.status,
                           rsp_bus.status);
               end
               if (rsp_bus.match_slot !== x.match_slot) begin
                  fail_count++;
                  $display("%0t: match_slot expected %0d actual %0d", $time, x.match_slot,
                           rsp_bus.match_slot);
               end
               if (rsp_bus.best_score !== x.best_score) begin
                  fail_count++;
                  $display("%0t: best_score expected %0d actual %0d", $time, x.best_score,
                           rsp_bus.best_score);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) threshold = csr_bus.data;
         if (req_bus.valid && req_bus.ready)
            take_beat(req_bus.opcode, req_bus.slot, req_bus.element, req_bus.last);
         pending = awaited_results.size();
      end
   end

endmodule

/* tb/cosine_nearest_match_table_unit_tb.sv */
// Stimulus, clock, reset and verdict for the cosine nearest-match table testbench.
module cosine_nearest_match_table_unit_tb;
   import cnm_pkg::*;

   // The opcode value that the block must ignore entirely.
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cnm_req_if req_bus ();
   cnm_rsp_if rsp_bus ();
   cnm_csr_if csr_bus ();

   int fail_count, pending, checked;
   int cycles = 0;
   int beats_sent = 0;
   int thresholds_set = 0;
   int hold_cycles = 0;

   // Shadow of the vectors that full-length adds have committed, used to build queries that
   // land close to a stored entry. It only steers stimulus; the checker owns the prediction.
   logic signed [ELEM_W-1:0] known_vec[ENTRIES][DIM];
   bit                       known_live[ENTRIES];
   logic signed [ELEM_W-1:0] work_vec[DIM];

   cosine_nearest_match_table_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cnm_match_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #4 clock = ~clock;

   // The timeout counts every cycle; a healthy run ends far below the limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side. It draws a random wait before each beat, and when the stimulus asks for a
   // long hold it drops ready for that many cycles so that the output register backs up.
   initial begin
      int w, n;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (w) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid && hold_cycles == 0);
      end
   end

   // One request beat: an optional idle gap, then valid held until the block takes it. With
   // no gap valid stays high from the previous beat, so it is never lowered and raised again
   // in one step.
   task automatic send(input logic [OP_W-1:0] op, input logic [SLOT_FW-1:0] s,
                       input logic signed [ELEM_W-1:0] e, input logic l);
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.slot    <= s;
      req_bus.element <= e;
      req_bus.last    <= l;
      do @(posedge clock); while (!req_bus.ready);
      if (op != OP_IGNORED) beats_sent++;
   endtask

   // Waits until every predicted response has come back, then lets the block settle.
   task automatic drain;
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [SCORE_W-1:0] value);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      thresholds_set++;
   endtask

   // Streams work_vec, wrapping around when len exceeds DIM.
   task automatic send_stream(input logic [OP_W-1:0] op, input logic [SLOT_FW-1:0] s,
                              input int len);
      for (int i = 0; i < len; i++) send(op, s, work_vec[i % DIM], i == len - 1);
   endtask

   // Fills work_vec with one of several kinds of content. Near copies and negated copies of
   // stored entries give high and low scores; zero vectors exercise the zero-norm rule.
   task automatic make_vector(input bit allow_copy);
      int kind, src, amp;
      kind = $urandom_range(0, 9);
      src  = $urandom_range(0, ENTRIES - 1);
      amp  = $urandom_range(1, 4000);
      if (kind >= 6 && (!allow_copy || !known_live[src])) kind = 0;
      for (int i = 0; i < DIM; i++) begin
         case (kind) inside
            0, 1: work_vec[i] = ELEM_W'($urandom_range(0, 65535));
            2, 3: work_vec[i] = ELEM_W'($signed($urandom_range(0, 2 * amp)) - amp);
            4: work_vec[i] = ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000) : 16'sh0000;
            5: work_vec[i] = 16'sh0000;
            6, 7, 8: work_vec[i] = ELEM_W'(known_vec[src][i] + $urandom_range(0, 64) - 32);
            default: work_vec[i] = -known_vec[src][i];
         endcase
      end
   endtask

   task automatic full_add(input logic [SLOT_FW-1:0] s);
      make_vector(1'b0);
      send_stream(OP_ADD, s, DIM);
      if (!known_live[s]) begin
         known_live[s] = 1'b1;
         for (int i = 0; i < DIM; i++) known_vec[s][i] = work_vec[i];
      end
   endtask

   task automatic delete_slot(input logic [SLOT_FW-1:0] s);
      send(OP_DEL, s, ELEM_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      known_live[s] = 1'b0;
   endtask

   function automatic logic [SLOT_FW-1:0] pick_slot(input bit want_free);
      int s;
      for (int t = 0; t < 20; t++) begin
         s = $urandom_range(0, ENTRIES - 1);
         if (known_live[s] != want_free) return SLOT_FW'(s);
      end
      return SLOT_FW'(s);
   endfunction

   initial begin
      int r, len, next_phase;
      logic [SCORE_W-1:0] phase_thresholds[5];
      int phase;
      phase_thresholds = '{16'd65535, 16'd0, 16'd32768, 16'd49152, 16'd40000};
      req_bus.valid   <= 1'b0;
      req_bus.opcode  <= OP_ADD;
      req_bus.slot    <= '0;
      req_bus.element <= '0;
      req_bus.last    <= 1'b0;
      csr_bus.valid   <= 1'b0;
      csr_bus.data    <= '0;
      for (int k = 0; k < ENTRIES; k++) known_live[k] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: deletes of empty slots at both ends, short streams that end in a length
      // error, an ignored opcode, a stream switch by slot and by opcode,
      // and a delete that leaves an open add stream alone.
      send(OP_DEL, 6'd0, 16'sh0000, 1'b0);
      send(OP_DEL, 6'd63, 16'sh7fff, 1'b1);
      send(OP_ADD, 6'd63, 16'sh8000, 1'b1);
      send(OP_QRY, 6'd0, 16'sh7fff, 1'b1);
      send(OP_IGNORED, 6'd63, 16'sh8000, 1'b1);
      send(OP_ADD, 6'd5, 16'sh1234, 1'b0);
      send(OP_DEL, 6'd5, 16'sh0001, 1'b0);
      send(OP_ADD, 6'd5, 16'shedcb, 1'b0);
      send(OP_ADD, 6'd6, 16'sh7fff, 1'b0);
      send(OP_QRY, 6'd6, 16'sh8000, 1'b0);
      send(OP_QRY, 6'd1, 16'sh0000, 1'b1);
      send(OP_ADD, 6'd0, 16'shffff, 1'b1);
      send(OP_QRY, 6'd42, 16'sh0001, 1'b1);

      // Back pressure: the receiver holds off while deletes keep coming, so the output
      // register fills and the request side must stall.
      hold_cycles = 300;
      for (int i = 0; i < 10; i++) send(OP_DEL, SLOT_FW'($urandom_range(0, 63)), 16'sh0000,
                                        1'b0);
      drain();

      phase      = 0;
      next_phase = beats_sent + 300;
      while (beats_sent < 1650) begin
         if (beats_sent >= next_phase && phase < 5) begin
            write_threshold(phase_thresholds[phase]);
            phase++;
            next_phase = beats_sent + 300;
         end
         r = $urandom_range(0, 99);
         if (r < 30) begin
            full_add(pick_slot($urandom_range(0, 9) < 8));
         end else if (r < 55) begin
            make_vector(1'b1);
            send_stream(OP_QRY, 6'($urandom_range(0, 63)), DIM);
         end else if (r < 70) begin
            delete_slot(pick_slot($urandom_range(0, 9) < 3));
         end else if (r < 82) begin
            // A stream with the wrong length.
            make_vector(1'b0);
            len = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 10) :
                  $urandom_range(DIM - 1, DIM + 3);
            if (len == DIM) len = DIM + 1;
            send_stream(($urandom_range(0, 1) == 1) ? OP_QRY : OP_ADD,
                        pick_slot(1'b1), len);
         end else if (r < 90) begin
            // A partial stream abandoned for another one, which then completes.
            make_vector(1'b0);
            send_stream(OP_ADD, pick_slot(1'b1), $urandom_range(1, 20));
            if ($urandom_range(0, 1) == 1) full_add(pick_slot(1'b1));
            else begin
               make_vector(1'b1);
               send_stream(OP_QRY, 6'd0, DIM);
            end
         end else if (r < 95) begin
            send(OP_IGNORED, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
         end else begin
            // A delete in the middle of an add stream does not disturb it.
            make_vector(1'b0);
            len = $urandom_range(1, DIM - 1);
            r   = int'(pick_slot(1'b1));
            for (int i = 0; i < DIM; i++) begin
               if (i == len) send(OP_DEL, pick_slot(1'b0), 16'sh0000, 1'b0);
               send(OP_ADD, SLOT_FW'(r), work_vec[i], i == DIM - 1);
            end
            if (!known_live[r]) begin
               known_live[r] = 1'b1;
               for (int i = 0; i < DIM; i++) known_vec[r][i] = work_vec[i];
            end
         end
      end

      drain();
      $display("Run covered %0d request beats and %0d checked responses, with %0d threshold",
               beats_sent, checked, thresholds_set);
      $display("settings, slot reuse, deletes, length errors, stream switches and scans.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
